@@ rtl/mxh_pkg.sv @@
// Shared constants, types and helpers for the multiply/xorshift hash unit.
package mxh_pkg;

    // Hash constants
    localparam logic [63:0] GOLDEN_ADD = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] WORD_MUL   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FINAL_MUL  = 64'hc4ce_b9fe_1a85_ec53;
    localparam int unsigned MIX_SHIFT  = 33;
    localparam logic [63:0] SEED_RESET = 64'h5344_464a_434b_3031;

    // Default width of the byte counter
    localparam int unsigned LENGTH_BITS_DEF = 32;

    // Word geometry
    localparam logic [3:0] BYTES_PER_WORD = 4'd8;

    // Queue between front and back: depth is a power of two
    localparam int unsigned Q_AW    = 1;
    localparam int unsigned Q_DEPTH = 1 << Q_AW;

    // Config register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 1'b1;

    // Classified word as it travels through the queue
    typedef struct packed {
        logic [63:0] word;   // masked to the valid bytes
        logic [3:0]  count;  // valid bytes, clamped to eight
        logic        last;
        logic        full;   // all eight bytes valid
    } t_item;

    // Request to the shared multiplier
    typedef struct packed {
        logic start;
        logic fin;           // 1: final constant, 0: word constant
    } t_mul_req;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_WORD,
        ST_MUL_FIN,
        ST_RESULT
    } t_state;

    // h ^ (h >> 33)
    function automatic logic [63:0] xorshift(input logic [63:0] h);
        return h ^ (h >> MIX_SHIFT);
    endfunction

endpackage

@@ rtl/multiply_xorshift_hash64_unit.sv @@
// Top level of the streaming 64-bit multiply/xorshift hash unit.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_data_word, i_valid_bytes, i_is_last
//   out      source     o_out_valid / i_out_stall  o_hash_value, o_length_mismatch
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// In the back end, the issue cycle of a full word also forms the low 32x32 product,
// then the a_lo*b_hi and a_hi*b_lo cross products are added, and the sequencer takes the result.
// A short last word adds a result state that loads the output register; a full last
// word runs the multiplier twice. A two-word queue lets the front keep taking words
// while the back works or the result waits. Reset is synchronous, active low, and
// needs no clearing pass. The config port is always ready.
module multiply_xorshift_hash64_unit #(
    parameter int unsigned LENGTH_BITS = mxh_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [63:0]                    i_data_word,
    input  logic [3:0]                     i_valid_bytes,
    input  logic                           i_is_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [63:0]                    o_hash_value,
    output logic                           o_length_mismatch,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mxh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import mxh_pkg::*;

    logic [63:0]            r_seed;
    logic [31:0]            r_msg_len;
    logic [63:0]            w_len64;
    logic [LENGTH_BITS-1:0] w_len;

    logic     w_push;
    logic     w_pop;
    logic     w_q_full;
    logic     w_q_empty;
    t_item    w_in_item;
    t_item    w_q_item;
    t_mul_req w_mul_req;
    logic [63:0] w_mul_a;
    logic        w_mul_done;
    logic [63:0] w_mul_prod;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= SEED_RESET;
            r_msg_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SEED: r_seed    <= i_cfg_data;
                CFG_LEN:  r_msg_len <= i_cfg_data[31:0];
                default:  r_seed    <= r_seed;
            endcase
        end
    end

    // Length taken modulo 2^LENGTH_BITS
    assign w_len64 = 64'(r_msg_len);
    assign w_len   = w_len64[LENGTH_BITS-1:0];

    mxh_front u_front (
        .i_in_valid    (i_in_valid),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_is_last     (i_is_last),
        .i_q_full      (w_q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_item        (w_in_item)
    );

    mxh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    mxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .i_a     (w_mul_a),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    mxh_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_seed            (r_seed),
        .i_len             (w_len),
        .i_q_empty         (w_q_empty),
        .i_item            (w_q_item),
        .o_pop             (w_pop),
        .o_mul_req         (w_mul_req),
        .o_mul_a           (w_mul_a),
        .i_mul_done        (w_mul_done),
        .i_mul_prod        (w_mul_prod),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_hash_value      (o_hash_value),
        .o_length_mismatch (o_length_mismatch)
    );

endmodule

@@ rtl/mxh_front.sv @@
// Front end: accepts input words, clamps the byte count and masks unused bytes.
module mxh_front (
    input  logic          i_in_valid,
    input  logic [63:0]   i_data_word,
    input  logic [3:0]    i_valid_bytes,
    input  logic          i_is_last,
    input  logic          i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output mxh_pkg::t_item o_item
);
    import mxh_pkg::*;

    logic [3:0]  w_count;
    logic [63:0] w_word;

    // Counts above eight mean a full word
    assign w_count = (i_valid_bytes > BYTES_PER_WORD) ? BYTES_PER_WORD : i_valid_bytes;

    // Zero the bytes past the valid count
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_word[b*8 +: 8] = (4'(b) < w_count) ? i_data_word[b*8 +: 8] : 8'h00;
        end
    end

    assign o_item.word  = w_word;
    assign o_item.count = w_count;
    assign o_item.last  = i_is_last;
    assign o_item.full  = (w_count == BYTES_PER_WORD);

    // Hold off the source while the queue is full
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

@@ rtl/mxh_fifo.sv @@
// Short queue of classified words between front and back end.
module mxh_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mxh_pkg::t_item i_item,
    input  logic           i_pop,
    output mxh_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);
    import mxh_pkg::*;

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + Q_AW'(1);
            if (w_pop)  r_rp <= r_rp + Q_AW'(1);
            if (w_push && !w_pop)      r_cnt <= r_cnt + (Q_AW+1)'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - (Q_AW+1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

endmodule

@@ rtl/mxh_mul.sv @@
// Shared multicycle multiplier: low 64 bits of operand times a hash constant.
module mxh_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mxh_pkg::t_mul_req i_req,
    input  logic [63:0]       i_a,
    output logic              o_done,
    output logic [63:0]       o_prod
);
    import mxh_pkg::*;

    localparam logic [1:0] STEP_LO_HI = 2'd1;  // a_lo * b_hi
    localparam logic [1:0] STEP_HI_LO = 2'd2;  // a_hi * b_lo

    logic [63:0] r_a;
    logic        r_fin;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_prod;

    logic [63:0] w_b_new;
    logic [63:0] w_b;
    logic [63:0] w_p0;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [31:0] w_cross;

    assign w_b_new = i_req.fin ? FINAL_MUL : WORD_MUL;
    assign w_b     = r_fin ? FINAL_MUL : WORD_MUL;

    // Low partial product, taken at start
    assign w_p0 = 64'(i_a[31:0]) * 64'(w_b_new[31:0]);

    // Cross products, low halves only, one per cycle
    assign w_ma    = (r_step == STEP_LO_HI) ? r_a[31:0]  : r_a[63:32];
    assign w_mb    = (r_step == STEP_LO_HI) ? w_b[63:32] : w_b[31:0];
    assign w_cross = w_ma * w_mb;

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= STEP_LO_HI;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == STEP_HI_LO) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Accumulate the product
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_a;
            r_fin  <= i_req.fin;
            r_prod <= w_p0;
        end else if (r_busy) begin
            r_prod[63:32] <= r_prod[63:32] + w_cross;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

@@ rtl/mxh_back.sv @@
// Back end: per-message state, mixing sequence and the result register.
module mxh_back #(
    parameter int unsigned LENGTH_BITS = mxh_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [63:0]            i_seed,
    input  logic [LENGTH_BITS-1:0] i_len,
    input  logic                   i_q_empty,
    input  mxh_pkg::t_item         i_item,
    output logic                   o_pop,
    output mxh_pkg::t_mul_req      o_mul_req,
    output logic [63:0]            o_mul_a,
    input  logic                   i_mul_done,
    input  logic [63:0]            i_mul_prod,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [63:0]            o_hash_value,
    output logic                   o_length_mismatch
);
    import mxh_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [63:0]            r_hash;
    logic [LENGTH_BITS-1:0] r_bytes;
    logic                   r_in_msg;
    logic                   r_short;
    logic                   r_pend_fin;
    logic                   r_out_valid;
    logic [63:0]            r_hash_out;
    logic                   r_mis;

    logic [63:0]            w_init;
    logic [63:0]            w_hbase;
    logic [LENGTH_BITS-1:0] w_bbase;
    logic                   w_sbase;
    logic [LENGTH_BITS:0]   w_sum;
    logic [LENGTH_BITS-1:0] w_bsat;
    logic [63:0]            w_mixed;
    logic                   w_out_free;
    logic                   w_load;

    // Start of message: seed mixed with golden constant plus length
    assign w_init  = i_seed ^ (GOLDEN_ADD + 64'(i_len));
    assign w_hbase = r_in_msg ? r_hash  : w_init;
    assign w_bbase = r_in_msg ? r_bytes : '0;
    assign w_sbase = r_in_msg ? r_short : 1'b0;

    // Saturating byte count
    assign w_sum  = {1'b0, w_bbase} + (LENGTH_BITS+1)'(i_item.count);
    assign w_bsat = w_sum[LENGTH_BITS] ? '1 : w_sum[LENGTH_BITS-1:0];

    assign w_mixed    = xorshift(i_mul_prod);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_item.last && !i_item.full) ? ST_MUL_FIN : ST_MUL_WORD;
                end
            end
            ST_MUL_WORD: begin
                if (i_mul_done) n_state = r_pend_fin ? ST_MUL_FIN : ST_IDLE;
            end
            ST_MUL_FIN: begin
                if (i_mul_done) n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop     = 1'b0;
        o_mul_req = '0;
        o_mul_a   = w_hbase ^ i_item.word;
        w_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop         = 1'b1;
                    o_mul_req.start = 1'b1;
                    o_mul_req.fin   = i_item.last && !i_item.full;
                end
            end
            ST_MUL_WORD: begin
                // full final word: empty tail, go on to the final multiply
                if (i_mul_done && r_pend_fin) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.fin   = 1'b1;
                    o_mul_a         = w_mixed;
                end
            end
            ST_MUL_FIN: begin
                o_pop = 1'b0;
            end
            ST_RESULT: begin
                w_load = w_out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Control state and message bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_msg    <= 1'b0;
            r_bytes     <= '0;
            r_short     <= 1'b0;
            r_pend_fin  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_in_msg   <= 1'b1;
                r_bytes    <= w_bsat;
                r_short    <= w_sbase || (!i_item.last && !i_item.full);
                r_pend_fin <= i_item.last && i_item.full;
            end
            if (w_load) begin
                r_in_msg <= 1'b0;
                r_bytes  <= '0;
                r_short  <= 1'b0;
            end
            if (w_load)            r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Running hash and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL_WORD && i_mul_done) r_hash <= w_mixed;
        if (w_load) begin
            r_hash_out <= w_mixed;
            r_mis      <= r_short || (r_bytes != i_len);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_hash_out;
    assign o_length_mismatch = r_mis;

endmodule

@@ rtl/mxh_checker.sv @@
// Port-level checks for the hash unit, bound to the top level.
module mxh_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [63:0]                   o_hash_value,
    input logic                          o_length_mismatch
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_hash_value) && $stable(o_length_mismatch))
        else $error("result payload changed while stalled");

    // Reset empties the queue and the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("state not cleared by reset");

    // The queue only fills up right after it took a word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall raised without an accepted word");

endmodule

bind multiply_xorshift_hash64_unit mxh_checker u_chk (.*);
